/* rtl/lac_pkg.sv */
// Shared constants and control types for the lagged autocovariance block.
// No dependencies; every other file except lac_ram imports this package.
package lac_pkg;

  // Series storage
  localparam int MAX_LEN   = 32;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SAMPLE_W  = 8;
  localparam int MAG_W     = SAMPLE_W - 1;
  localparam int LAG_W     = 5;
  localparam logic [LAG_W-1:0] LAG_RESET = LAG_W'(1);
  localparam int CMP_W     = (CNT_W > LAG_W) ? CNT_W : LAG_W;

  // Missing-value threshold, and the pair count that a valid result must exceed
  localparam int MISSING_AT = 128;
  localparam int MIN_PAIRS  = 5;
  localparam int FRAC_BITS  = 8;

  // Running sum widths
  localparam int MAG_MAX = MISSING_AT - 1;
  localparam int SUM_W   = $clog2(MAX_LEN * MAG_MAX + 1);
  localparam int PROD_W  = $clog2(MAX_LEN * MAG_MAX * MAG_MAX + 1);
  localparam int SQ_W    = 2 * MAG_W;

  // Final arithmetic widths
  localparam int PN_W    = PROD_W + CNT_W;
  localparam int SL_W    = 2 * SUM_W;
  localparam int NUM_W   = ((PN_W > SL_W) ? PN_W : SL_W) + 1;
  localparam int DVD_W   = NUM_W + FRAC_BITS;
  localparam int DEN_W   = CNT_W + 1;
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  // Result fields
  localparam int OUT_W = 29;
  localparam int PC_W  = 6;
  localparam int PC_MAX = 63;
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Controller to datapath
  typedef struct packed {
    logic load;      // take an input request
    logic accum;     // fold the pair into the running sums
    logic mul;       // form P*n and S*L
    logic div_init;  // set up the rounding divide
    logic div_step;  // one quotient bit
    logic finish;    // load the result register, clear the series
  } lac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic div_done;
  } lac_stat_t;

endpackage

/* rtl/lac_if.sv */
// Valid/ready channel interfaces for sample input, result output and lag config.
// Depends on lac_pkg for field widths.
interface lac_in_if import lac_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface lac_out_if import lac_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] autocovariance;
  logic [PC_W-1:0]         pair_count;
  logic                    valid_res;
  modport source (output valid, autocovariance, pair_count, valid_res, input ready);
  modport sink   (input valid, autocovariance, pair_count, valid_res, output ready);
endinterface

interface lac_cfg_if import lac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LAG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/lagged_autocovariance_flagged.sv */
// Lagged autocovariance of a flagged byte series. Each sample request is
// taken in the idle state: the sample is written to the 32-entry store while
// the partner lag positions back is read, then the pair is folded into the
// running sums on the next cycle, and no new sample is taken before that. A
// request marked last then runs the multiply step, the divide setup step, the
// bit-serial rounding divider and its done check, and the load of the result
// register, and only then does the next series start, later still if the
// previous result has not been taken. The lag port is always ready and takes
// effect on the next sample. The store needs no clearing pass after reset:
// only entries of the current series are read.
// Depends on lac_pkg, lac_if, lac_ram, lac_ctrl and lac_dp.
module lagged_autocovariance_flagged import lac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lac_in_if.sink      in_ch,
  lac_out_if.source   out_ch,
  lac_cfg_if.sink     cfg_ch
);

  lac_cmd_t  cmd;
  lac_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  // Sequencer
  lac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  lac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_sample (in_ch.sample),
    .in_last   (in_ch.last),
    .cfg_we    (cfg_ch.valid && cfg_ch.ready),
    .cfg_lag   (cfg_ch.data),
    .out_cov   (out_ch.autocovariance),
    .out_pc    (out_ch.pair_count),
    .out_ok    (out_ch.valid_res)
  );

endmodule

/* rtl/lac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lac_ctrl.sv */
// Sequencer for the lagged autocovariance block: handshakes and step commands.
// Depends on lac_pkg.
module lac_ctrl import lac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  lac_stat_t stat,
  output lac_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DINIT = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_fire;
        if (in_fire) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = stat.last ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = !stat.div_done;
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // wait until the result register is free
        cmd.finish = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted sample is always folded in on the next cycle
  a_fire_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_ACC)
    else $error("accepted sample not followed by accumulate");

  // Divide setup leads into a divide with work remaining
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DINIT |=> (state_r == S_DIV) && !stat.div_done)
    else $error("divide did not start after setup");

  // A result appears only out of the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish");

endmodule

/* rtl/lac_dp.sv */
// Datapath: sample store, running sums, final multiply and rounding divider.
// Depends on lac_pkg and lac_ram.
module lac_dp import lac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lac_cmd_t                cmd,
  output lac_stat_t               stat,
  input  logic [SAMPLE_W-1:0]     in_sample,
  input  logic                    in_last,
  input  logic                    cfg_we,
  input  logic [LAG_W-1:0]        cfg_lag,
  output logic signed [OUT_W-1:0] out_cov,
  output logic [PC_W-1:0]         out_pc,
  output logic                    out_ok
);

  // Configuration
  logic [LAG_W-1:0] lag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r <= LAG_RESET;
    end else if (cfg_we) begin
      lag_r <= cfg_lag;
    end
  end

  // Series control state
  logic [CNT_W-1:0]  idx_r;
  logic [SUM_W-1:0]  s_r, l_r;
  logic [PROD_W-1:0] p_r;
  logic [CNT_W-1:0]  n_r;

  // Per-request registers
  logic [SAMPLE_W-1:0] sample_r;
  logic                last_r;
  logic                pair_ok_r;
  logic                lag_zero_r;

  // Store addressing
  logic                room;
  logic [CMP_W-1:0]    k_ext, lag_ext, back;
  logic [IDX_W-1:0]    raddr;
  logic [SAMPLE_W-1:0] rdata;

  assign room    = idx_r < CNT_W'(MAX_LEN);
  assign k_ext   = CMP_W'(idx_r);
  assign lag_ext = CMP_W'(lag_r);
  assign back    = k_ext - lag_ext;
  assign raddr   = back[IDX_W-1:0];

  lac_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (idx_r[IDX_W-1:0]),
    .wdata (in_sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r   <= in_sample;
      last_r     <= in_last;
      pair_ok_r  <= room && (k_ext >= lag_ext);
      lag_zero_r <= (lag_r == '0);
    end
  end

  // Pair qualification; zero lag pairs a sample with itself
  logic [SAMPLE_W-1:0] lead;
  logic                take;
  logic [SQ_W-1:0]     sq;

  assign lead = lag_zero_r ? sample_r : rdata;
  assign take = pair_ok_r && (lead < SAMPLE_W'(MISSING_AT))
                && (sample_r < SAMPLE_W'(MISSING_AT));
  assign sq   = lead[MAG_W-1:0] * sample_r[MAG_W-1:0];

  // Running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      s_r   <= '0;
      l_r   <= '0;
      p_r   <= '0;
      n_r   <= '0;
    end else if (cmd.finish) begin
      idx_r <= '0;
      s_r   <= '0;
      l_r   <= '0;
      p_r   <= '0;
      n_r   <= '0;
    end else begin
      if (cmd.load && room) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.accum && take) begin
        s_r <= s_r + SUM_W'(lead[MAG_W-1:0]);
        l_r <= l_r + SUM_W'(sample_r[MAG_W-1:0]);
        p_r <= p_r + PROD_W'(sq);
        n_r <= n_r + CNT_W'(1);
      end
    end
  end

  // P*n and S*L, registered
  logic [PN_W-1:0] pn_r, pn_nxt;
  logic [SL_W-1:0] sl_r, sl_nxt;

  assign pn_nxt = {{CNT_W{1'b0}}, p_r} * {{PROD_W{1'b0}}, n_r};
  assign sl_nxt = {{SUM_W{1'b0}}, s_r} * {{SUM_W{1'b0}}, l_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pn_r <= pn_nxt;
      sl_r <= sl_nxt;
    end
  end

  // Rounding divide: floor((|num|*512 + n) / 2n), one bit a cycle
  logic [NUM_W-1:0]  diff, mag;
  logic [DVD_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic              neg_r;
  logic [DCNT_W-1:0] dcnt_r;

  assign diff    = NUM_W'(pn_r) - NUM_W'(sl_r);
  assign mag     = diff[NUM_W-1] ? (NUM_W'(0) - diff) : diff;
  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r <= {mag[NUM_W-2:0], (FRAC_BITS+1)'(n_r)};
      rem_r <= '0;
      den_r <= {n_r, 1'b0};
      neg_r <= diff[NUM_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_init) begin
      dcnt_r <= DCNT_W'(DVD_W);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  assign stat.last     = last_r;
  assign stat.div_done = (dcnt_r == '0);

  // Sign, saturation and the few-pairs rule
  logic                ok;
  logic [OUT_W-1:0]    cov_val, cov_nxt;
  logic [CNT_W+PC_W-1:0] n_wide;
  logic [PC_W-1:0]     pc_nxt;

  assign ok = n_r > CNT_W'(MIN_PAIRS);

  always_comb begin
    if (neg_r) begin
      cov_val = (quo_r > DVD_W'(OUT_MIN)) ? OUT_MIN : (OUT_W'(0) - OUT_W'(quo_r));
    end else begin
      cov_val = (quo_r > DVD_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(quo_r);
    end
  end

  assign cov_nxt = ok ? cov_val : '0;
  assign n_wide  = (CNT_W+PC_W)'(n_r);
  assign pc_nxt  = (n_wide > (CNT_W+PC_W)'(PC_MAX)) ? PC_W'(PC_MAX) : PC_W'(n_wide);

  // Result register
  logic [OUT_W-1:0] cov_r;
  logic [PC_W-1:0]  pc_r;
  logic             ok_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cov_r <= cov_nxt;
      pc_r  <= pc_nxt;
      ok_r  <= ok;
    end
  end

  assign out_cov = $signed(cov_r);
  assign out_pc  = pc_r;
  assign out_ok  = ok_r;

  // Sample count never exceeds the store depth
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CNT_W'(MAX_LEN))
    else $error("sample index beyond store depth");

  // Each pair needs a stored sample
  a_pairs_le_idx: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= idx_r)
    else $error("more pairs than samples");

  // Partial remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step && (den_r != '0) |-> rem_r < den_r)
    else $error("divider remainder out of range");

endmodule
